[rtl/inpc_pkg.sv]
// ----------------------------------------------------------------------------
// Impulse noise pixel counter package
// Shared types, register map codes and fixed constants of the counter.
// ----------------------------------------------------------------------------
package inpc_pkg;

  localparam int PIXEL_W = 8;
  localparam int DIM_W   = 13;
  localparam int MIND_W  = 3;
  localparam int ROW_W   = 12;
  localparam int TALLY_W = 24;
  localparam int COUNT_W = 25;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [MIND_W-1:0]  mind_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [TALLY_W-1:0] tally_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DATA_W-1:0]  data_t;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DIFF_THRESHOLD = 2'd2,
    REG_MIN_DIFFERING  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    dim_t   frame_width;
    dim_t   frame_height;
    pixel_t diff_threshold;
    mind_t  min_differing;
  } cfg_t;

  localparam dim_t   FRAME_WIDTH_RST    = 13'd640;
  localparam dim_t   FRAME_HEIGHT_RST   = 13'd480;
  localparam pixel_t DIFF_THRESHOLD_RST = 8'd50;
  localparam mind_t  MIN_DIFFERING_RST  = 3'd3;

  localparam dim_t   MIN_DIM      = 13'd3;
  localparam dim_t   HEIGHT_LIMIT = 13'd4096;
  localparam tally_t TALLY_MAX    = 24'hFF_FFFF;
  localparam pixel_t PIXEL_SALT   = 8'hFF;
  localparam pixel_t PIXEL_PEPPER = 8'h00;

endpackage

[rtl/inpc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module inpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[rtl/inpc_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding frame size and detection settings.
// ----------------------------------------------------------------------------
module inpc_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  inpc_pkg::addr_t paddr,
  input  inpc_pkg::data_t pwdata,
  output inpc_pkg::data_t prdata,
  output logic           pready,
  output inpc_pkg::cfg_t  cfg_o
);
  import inpc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:    cfg_d.frame_width    = pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:   cfg_d.frame_height   = pwdata[DIM_W-1:0];
        REG_DIFF_THRESHOLD: cfg_d.diff_threshold = pwdata[PIXEL_W-1:0];
        REG_MIN_DIFFERING:  cfg_d.min_differing  = pwdata[MIND_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:    prdata = DATA_W'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:   prdata = DATA_W'(cfg_q.frame_height);
      REG_DIFF_THRESHOLD: prdata = DATA_W'(cfg_q.diff_threshold);
      REG_MIN_DIFFERING:  prdata = DATA_W'(cfg_q.min_differing);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= FRAME_WIDTH_RST;
      cfg_q.frame_height   <= FRAME_HEIGHT_RST;
      cfg_q.diff_threshold <= DIFF_THRESHOLD_RST;
      cfg_q.min_differing  <= MIN_DIFFERING_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/inpc_judge.sv]
// ----------------------------------------------------------------------------
// Cross window judge
// Decides whether a center pixel is an impulse against its four neighbors.
// ----------------------------------------------------------------------------
module inpc_judge (
  input  inpc_pkg::pixel_t center_i,
  input  inpc_pkg::pixel_t up_i,
  input  inpc_pkg::pixel_t down_i,
  input  inpc_pkg::pixel_t left_i,
  input  inpc_pkg::pixel_t right_i,
  input  inpc_pkg::pixel_t threshold_i,
  input  inpc_pkg::mind_t  min_differing_i,
  output logic             impulse_o
);
  import inpc_pkg::*;

  pixel_t     nbr [4];
  logic [3:0] differs;
  mind_t      count;
  logic       extreme;

  assign nbr[0] = up_i;
  assign nbr[1] = down_i;
  assign nbr[2] = left_i;
  assign nbr[3] = right_i;

  // A neighbor differs when the absolute difference exceeds the threshold.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (center_i > nbr[k]) begin
        differs[k] = (center_i - nbr[k]) > threshold_i;
      end else begin
        differs[k] = (nbr[k] - center_i) > threshold_i;
      end
    end
  end

  assign count = mind_t'(differs[0]) + mind_t'(differs[1])
               + mind_t'(differs[2]) + mind_t'(differs[3]);

  assign extreme   = (center_i == PIXEL_PEPPER) || (center_i == PIXEL_SALT);
  assign impulse_o = extreme && (count >= min_differing_i);

endmodule

[rtl/impulse_noise_pixel_counter_core.sv]
// ----------------------------------------------------------------------------
// Impulse noise pixel counter
// Counts salt and pepper pixels of a raster frame with a cross window test
// and reports the count and the pixel total once per frame.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  -------------------------------
//   input     in_valid_i / in_stall_o      pixel_i (8 bits)
//   output    out_valid_o / out_stall_i    impulse_count_o, pixel_total_o
//   config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One pixel transaction is taken every clock cycle unless the input stalls.
// The rate is set by the line buffer RAM, which is read at the current and
// the next column while the previous pixel's column is written back in the
// same cycle. A frame's result passes the window and output registers.
// The input stalls only when a result waits on a stalled output and the next
// pixel would close another frame; stalls elsewhere are never needed.
// Reset clears the indices, the tally and the output; the line buffer is not
// cleared and needs no clearing pass, since rows are written before use.
//
// Pipeline: in the accept cycle the column index addresses the line buffer
// (one entry holds the row two above and the row above the incoming pixel).
// In the next cycle the cross window is complete: up and center come from
// the entry of the current column, right from the entry of the next column,
// down is the pixel itself and left is the center of the previous pixel,
// kept in a register. The entry is then rewritten with the shifted pair.
// Consecutive pixels never touch the same entry, so no forwarding beyond
// the left neighbor is needed.
module impulse_noise_pixel_counter_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  inpc_pkg::pixel_t pixel_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output inpc_pkg::count_t impulse_count_o,
  output inpc_pkg::count_t pixel_total_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  inpc_pkg::addr_t  paddr,
  input  inpc_pkg::data_t  pwdata,
  output inpc_pkg::data_t  prdata,
  output logic             pready
);
  import inpc_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMPW  = (WW > DIM_W) ? WW : DIM_W;
  localparam int PRODW = WW + DIM_W;
  localparam int TOTW  = (PRODW > COUNT_W) ? PRODW : COUNT_W;
  localparam int ENTW  = 2 * PIXEL_W;

  cfg_t cfg;

  inpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective frame size, saturated to the supported range.
  logic [CMPW-1:0] fw_ext;
  logic [WW-1:0]   eff_w;
  dim_t            eff_h;

  assign fw_ext = CMPW'(cfg.frame_width);

  always_comb begin
    if (fw_ext < CMPW'(MIN_DIM)) begin
      eff_w = WW'(MIN_DIM);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_ext);
    end
  end

  always_comb begin
    if (cfg.frame_height < MIN_DIM) begin
      eff_h = MIN_DIM;
    end else if (cfg.frame_height > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = cfg.frame_height;
    end
  end

  // Raster position of the next pixel.
  logic [CW-1:0] col_q, col_d;
  row_t          row_q, row_d;
  logic          col_end, row_end, interior, next_is_last, in_accept;

  assign col_end  = (CMPW'(col_q) + CMPW'(1)) >= CMPW'(eff_w);
  assign row_end  = (DIM_W'(row_q) + DIM_W'(1)) >= eff_h;
  assign interior = (row_q >= ROW_W'(2)) && (col_q != '0) && !col_end;
  assign next_is_last = col_end && row_end;

  // A frame-closing pixel waits while an older result is still held back.
  assign in_stall_o = out_valid_o && out_stall_i && next_is_last;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // Window stage, in the cycle after the accept.
  logic          s1_valid_q, s1_last_q, s1_interior_q;
  pixel_t        s1_px_q;
  logic [CW-1:0] s1_col_q;
  pixel_t        prev_center_q;

  logic [ENTW-1:0] rd_here, rd_next;
  pixel_t          up, center, right;
  logic            impulse, tally_inc;
  tally_t          tally_q, tally_d, tally_sum;

  inpc_ram #(
    .WIDTH (ENTW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (s1_valid_q),
    .waddr_i   (s1_col_q),
    .wdata_i   ({center, s1_px_q}),
    .raddr_a_i (col_q),
    .raddr_b_i (col_q + CW'(1)),
    .rdata_a_o (rd_here),
    .rdata_b_o (rd_next)
  );

  assign up     = rd_here[ENTW-1:PIXEL_W];
  assign center = rd_here[PIXEL_W-1:0];
  assign right  = rd_next[PIXEL_W-1:0];

  inpc_judge u_judge (
    .center_i        (center),
    .up_i            (up),
    .down_i          (s1_px_q),
    .left_i          (prev_center_q),
    .right_i         (right),
    .threshold_i     (cfg.diff_threshold),
    .min_differing_i (cfg.min_differing),
    .impulse_o       (impulse)
  );

  // The tally saturates rather than wrapping.
  assign tally_inc = s1_interior_q && impulse && (tally_q != TALLY_MAX);
  assign tally_sum = tally_q + TALLY_W'(tally_inc);

  always_comb begin
    tally_d = tally_q;
    if (s1_valid_q) begin
      tally_d = s1_last_q ? '0 : tally_sum;
    end
  end

  // Output register.
  logic            out_load, out_valid_d;
  logic [TOTW-1:0] total_full;

  assign out_load    = s1_valid_q && s1_last_q;
  assign out_valid_d = out_load || (out_valid_o && out_stall_i);
  assign total_full  = TOTW'(eff_w) * TOTW'(eff_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      s1_valid_q    <= 1'b0;
      s1_last_q     <= 1'b0;
      s1_interior_q <= 1'b0;
      tally_q       <= '0;
      out_valid_o   <= 1'b0;
    end else begin
      col_q         <= col_d;
      row_q         <= row_d;
      s1_valid_q    <= in_accept;
      s1_last_q     <= next_is_last;
      s1_interior_q <= interior;
      tally_q       <= tally_d;
      out_valid_o   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_px_q  <= pixel_i;
      s1_col_q <= col_q;
    end
    if (s1_valid_q) begin
      prev_center_q <= center;
    end
    if (out_load) begin
      impulse_count_o <= COUNT_W'(tally_sum);
      pixel_total_o   <= total_full[COUNT_W-1:0];
    end
  end

endmodule

[rtl/inpc_checker.sv]
// ----------------------------------------------------------------------------
// Impulse noise pixel counter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module inpc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input inpc_pkg::count_t impulse_count_o,
  input inpc_pkg::count_t pixel_total_o
);
  import inpc_pkg::*;

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(impulse_count_o)
      && $stable(pixel_total_o))
    else $error("result changed while stalled");

  // Input is held back only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // A new result traces back to an accepted pixel transaction.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a closing pixel");

  // The impulse tally saturates below the top bit of the field.
  a_tally_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !impulse_count_o[COUNT_W-1])
    else $error("impulse count beyond saturation");

endmodule

bind impulse_noise_pixel_counter_core inpc_checker u_inpc_checker (.*);

[sim/impulse_noise_pixel_counter_checker.sv]
// ----------------------------------------------------------------------------
// Impulse noise pixel counter checker
// Watches the pixel, result and register channels of the counter, keeps its
// own raster position, line stores and tally, and compares every frame
// result that leaves the block with the one it worked out.
// ----------------------------------------------------------------------------
module impulse_noise_pixel_counter_checker #(
  parameter int MAX_WIDTH    = 4096,
  parameter int REPORT_LIMIT = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  inpc_pkg::pixel_t pixel_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  inpc_pkg::count_t impulse_count_i,
  input  inpc_pkg::count_t pixel_total_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  inpc_pkg::addr_t  paddr,
  input  inpc_pkg::data_t  pwdata,
  input  logic             pready,
  output int               pending_o,
  output int               failures_o,
  output int               frames_o
);
  import inpc_pkg::*;

  typedef struct packed {
    count_t impulse_count;
    count_t pixel_total;
  } frame_result_t;

  frame_result_t expected_frames_q[$];

  cfg_t        cfg;
  pixel_t      row_older [MAX_WIDTH];
  pixel_t      row_newer [MAX_WIDTH];
  int unsigned col_idx;
  int unsigned row_idx;
  tally_t      tally;
  int          failures;
  int          frames;

  function automatic int unsigned clamp_dim(input dim_t v, input int unsigned hi);
    if (v < MIN_DIM) return 32'(MIN_DIM);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned neighbor_differs(input pixel_t ctr, input pixel_t nb);
    int unsigned d;
    d = (ctr > nb) ? ctr - nb : nb - ctr;
    return (d > cfg.diff_threshold) ? 1 : 0;
  endfunction

  // Advances the raster position by one pixel. The center one row up is
  // judged now, since the pixel below it has just arrived.
  task automatic take_pixel(input pixel_t px);
    int unsigned   w;
    int unsigned   h;
    int unsigned   c;
    int unsigned   r;
    int unsigned   hits;
    pixel_t        up;
    pixel_t        ctr;
    frame_result_t res;
    w   = clamp_dim(cfg.frame_width, MAX_WIDTH);
    h   = clamp_dim(cfg.frame_height, 32'(HEIGHT_LIMIT));
    c   = col_idx;
    r   = row_idx;
    up  = row_older[c];
    ctr = row_newer[c];
    if (r >= 2 && c >= 1 && c + 1 < w && (ctr == PIXEL_PEPPER || ctr == PIXEL_SALT)) begin
      // The older store at c-1 already holds the row of the center.
      hits = neighbor_differs(ctr, up) + neighbor_differs(ctr, px)
           + neighbor_differs(ctr, row_older[c-1]) + neighbor_differs(ctr, row_newer[c+1]);
      if (hits >= cfg.min_differing && tally != TALLY_MAX) tally++;
    end
    row_older[c] = ctr;
    row_newer[c] = px;
    if (c + 1 >= w) begin
      col_idx = 0;
      if (r + 1 >= h) begin
        res.impulse_count = count_t'(tally);
        res.pixel_total   = count_t'(w * h);
        expected_frames_q.insert(expected_frames_q.size(), res);
        row_idx = 0;
        tally   = '0;
      end else begin
        row_idx = r + 1;
      end
    end else begin
      col_idx = c + 1;
    end
  endtask

  always @(posedge clk_i) begin
    frame_result_t want;
    if (!rst_ni) begin
      cfg.frame_width    = FRAME_WIDTH_RST;
      cfg.frame_height   = FRAME_HEIGHT_RST;
      cfg.diff_threshold = DIFF_THRESHOLD_RST;
      cfg.min_differing  = MIN_DIFFERING_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_older[i] = '0;
        row_newer[i] = '0;
      end
      col_idx  = 0;
      row_idx  = 0;
      tally    = '0;
      failures = 0;
      frames   = 0;
      expected_frames_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_FRAME_WIDTH:    cfg.frame_width    = pwdata[DIM_W-1:0];
          REG_FRAME_HEIGHT:   cfg.frame_height   = pwdata[DIM_W-1:0];
          REG_DIFF_THRESHOLD: cfg.diff_threshold = pwdata[PIXEL_W-1:0];
          REG_MIN_DIFFERING:  cfg.min_differing  = pwdata[MIND_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_pixel(pixel_i);
      if (out_valid_i && !out_stall_i) begin
        frames++;
        if (expected_frames_q.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("[%0t] frame result with none expected: impulse_count %0d pixel_total %0d",
                     $realtime, impulse_count_i, pixel_total_i);
        end else begin
          want = expected_frames_q.pop_front();
          if (impulse_count_i !== want.impulse_count || pixel_total_i !== want.pixel_total) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("[%0t] frame %0d mismatch: impulse_count exp %0d got %0d, %s%0d got %0d",
                       $realtime, frames, want.impulse_count, impulse_count_i,
                       "pixel_total exp ", want.pixel_total, pixel_total_i);
          end
        end
      end
    end
    pending_o  <= expected_frames_q.size();
    failures_o <= failures;
    frames_o   <= frames;
  end

endmodule

[sim/tb_impulse_noise_pixel_counter_core.sv]
// ----------------------------------------------------------------------------
// Impulse noise pixel counter testbench
// Streams small raster frames through the counter under several register
// settings and handshake pressures, with a directed start and a mid-frame
// resize; a checker beside the block predicts and compares every frame
// result.
// ----------------------------------------------------------------------------
module tb_impulse_noise_pixel_counter_core;
  import inpc_pkg::*;

  // The result of a frame leaves the block through the window and output
  // registers; the settle time after a drained phase adds a comfortable margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int DIRECTED_PX   = 18;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  pixel_t pixel_i     = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  count_t impulse_count_o;
  count_t pixel_total_o;
  logic   psel        = 1'b0;
  logic   penable     = 1'b0;
  logic   pwrite      = 1'b0;
  addr_t  paddr       = '0;
  data_t  pwdata      = '0;
  data_t  prdata;
  logic   pready;

  int pending;
  int failures;
  int frames;

  // Idle pressure of the current phase, in percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned pixels_sent   = 0;
  int unsigned reg_writes    = 0;

  // Two hand-built 3x3 frames. The first has a salt center whose four
  // neighbors are all pepper, so it counts. The second has a pepper center
  // with one neighbor just past the threshold and two exactly at it, so only
  // two neighbors differ and it does not count. Corners carry odd values.
  pixel_t directed_px [DIRECTED_PX] = '{
    8'd7,   8'd0,   8'd128,
    8'd0,   8'd255, 8'd0,
    8'd254, 8'd0,   8'd1,
    8'd85,  8'd255, 8'd170,
    8'd51,  8'd0,   8'd50,
    8'd15,  8'd50,  8'd240
  };

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  impulse_noise_pixel_counter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_i         (pixel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .impulse_count_o (impulse_count_o),
    .pixel_total_o   (pixel_total_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  impulse_noise_pixel_counter_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .pixel_i         (pixel_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .impulse_count_i (impulse_count_o),
    .pixel_total_i   (pixel_total_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .pending_o       (pending),
    .failures_o      (failures),
    .frames_o        (frames)
  );

  // The result side stalls at random with the percentage of the phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // One register write: a setup phase, then the access phase until pready.
  // The bus is parked afterwards so that back-to-back writes never lower
  // and raise psel in the same time step.
  task automatic write_reg(input reg_idx_e idx, input data_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Loads all four registers and the idle pressure for the next phase.
  // Pressure modes: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly.
  task automatic set_frame(input dim_t w, input dim_t h, input pixel_t thr,
                           input mind_t md, input int unsigned mode);
    write_reg(REG_FRAME_WIDTH, data_t'(w));
    write_reg(REG_FRAME_HEIGHT, data_t'(h));
    write_reg(REG_DIFF_THRESHOLD, data_t'(thr));
    write_reg(REG_MIN_DIFFERING, data_t'(md));
    case (mode)
      1:       begin send_idle_pct = 62; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 62; end
      3:       begin send_idle_pct = 13; stall_pct = 13; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // One pixel transaction, preceded by random idle cycles. The payload is
  // held steady while the block stalls the input.
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
  endtask

  // Pixels lean heavily on salt and pepper so that interior centers are
  // often candidates; the rest spread over the whole range.
  task automatic stream_pixels(input int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (pick < 3) send_pixel(PIXEL_PEPPER);
      else if (pick < 6) send_pixel(PIXEL_SALT);
      else send_pixel(pixel_t'($urandom_range(255)));
    end
  endtask

  // Waits until every predicted result has left the block, then a little
  // longer, so that registers may be rewritten safely. The first cycle lets
  // the checker see the last transaction before its count is trusted.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_frames(input dim_t w, input dim_t h, input pixel_t thr,
                               input mind_t md, input int unsigned n_frames,
                               input int unsigned mode);
    set_frame(w, h, thr, md, mode);
    stream_pixels(n_frames * w * h);
    wait_idle();
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames. Width 0 and height 2 both saturate up to the 3x3
    // minimum, so this also covers the low end of the size clamp.
    set_frame(13'd0, 13'd2, 8'd50, 3'd3, 0);
    for (int i = 0; i < DIRECTED_PX; i++) send_pixel(directed_px[i]);
    wait_idle();

    // Fixed settings: threshold and needed-neighbor extremes. Zero needed
    // neighbors counts every interior salt or pepper pixel; seven can never
    // be met; a threshold of 255 means no neighbor ever differs.
    random_frames(13'd3, 13'd3, 8'd50,  3'd3, 12, 1);
    random_frames(13'd5, 13'd4, 8'd0,   3'd0, 8,  2);
    random_frames(13'd4, 13'd5, 8'd255, 3'd0, 8,  3);
    random_frames(13'd6, 13'd3, 8'd100, 3'd7, 8,  0);
    random_frames(13'd3, 13'd6, 8'd20,  3'd2, 8,  1);
    random_frames(13'd7, 13'd7, 8'd0,   3'd4, 4,  2);

    // Random small frames with random thresholds.
    for (int unsigned p = 0; p < 6; p++) begin
      w = $urandom_range(8, 3);
      h = $urandom_range(8, 3);
      random_frames(dim_t'(w), dim_t'(h), pixel_t'($urandom_range(255)),
                    mind_t'($urandom_range(4)), 3, p % 4);
    end

    // Resize in the middle of a frame. Two 6x6 frames plus 20 pixels leave
    // the position at row 3, column 2. Shrinking to 3x4 then ends the row
    // and the frame on the very next pixel; the line stores below column 3
    // all hold real pixels, so nothing unwritten is ever read.
    random_frames(13'd6, 13'd6, 8'd40, 3'd3, 2, 2);
    stream_pixels(20);
    wait_idle();
    set_frame(13'd3, 13'd4, 8'd60, 3'd1, 3);
    stream_pixels(1 + 10 * 12);
    wait_idle();

    $display("Sent %0d pixel transactions over %0d register writes; %0d frame results checked.",
             pixels_sent, reg_writes, frames);
    if (failures == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("Failures: %0d, results still expected: %0d", failures, pending);
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("Timeout with %0d results still expected", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
